FILE: sv/sri_pkg.sv
// ----------------------------------------------------------------------------
// Spectral rolloff index package
// Shared widths, defaults, transfer payload types and scan control type.
// ----------------------------------------------------------------------------
package sri_pkg;

   localparam int BIN_VALUE_W      = 16;
   localparam int RATIO_W          = 16;
   localparam int INDEX_W          = 9;
   localparam int DEF_MAX_BINS     = 512;
   localparam int DEF_BIN_WIDTH    = 16;
   localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd55706;

   typedef struct packed {
      logic [BIN_VALUE_W-1:0] bin_value;
      logic                   last_bin;
   } sri_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] rolloff_index;
      logic               overflow_flag;
   } sri_rsp_type;

   typedef struct packed {
      logic start;
      logic advance;
   } sri_scan_ctrl_type;

endpackage

FILE: sv/sri_bin_mem.sv
// ----------------------------------------------------------------------------
// Spectral rolloff bin memory
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sri_bin_mem
   import sri_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_BINS,
   parameter int WIDTH = DEF_BIN_WIDTH,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sri_scan.sv
// ----------------------------------------------------------------------------
// Spectral rolloff scan datapath
// Threshold product, running sum over stored bins and the exact reach compare.
// ----------------------------------------------------------------------------
module sri_scan
   import sri_pkg::*;
#(
   parameter int MAX_BINS  = DEF_MAX_BINS,
   parameter int BIN_WIDTH = DEF_BIN_WIDTH,
   localparam int PosW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1,
   localparam int SumW = BIN_WIDTH + PosW
) (
   input  logic              clock,
   input  sri_scan_ctrl_type ctrl,
   input  logic [SumW-1:0]   total,
   input  logic [RATIO_W-1:0] ratio,
   input  logic [BIN_WIDTH-1:0] rd_data,
   output logic              reach
);

   localparam int ProdW = SumW + RATIO_W;

   logic [ProdW-1:0] threshold_ff;
   logic [ProdW-1:0] threshold_in;
   logic [SumW-1:0]  running_ff;
   logic [SumW-1:0]  running_in;

   always_comb begin
      threshold_in = ProdW'(total) * ProdW'(ratio);
      running_in   = running_ff + SumW'(rd_data);
      reach        = {running_in, RATIO_W'(0)} >= threshold_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         threshold_ff <= threshold_in;
         running_ff   <= '0;
      end else if (ctrl.advance) begin
         running_ff <= running_in;
      end
   end

endmodule

FILE: sv/spectral_rolloff_index.sv
// Bins transfer one per cycle while a frame loads.
// After the last-bin transfer, the ST_THRESH state forms the threshold, the scan reads one
// stored bin per cycle from the single memory read port up to the rolloff index k,
// and ST_DONE registers the result, waiting while an earlier result is not yet taken.
// Reset clears the frame state and sets the ratio to 55706; the bin memory is not cleared.
// ----------------------------------------------------------------------------
// Spectral rolloff index
// Stores one frame of magnitude bins, then scans for the rolloff bin index.
// ----------------------------------------------------------------------------
module spectral_rolloff_index
   import sri_pkg::*;
#(
   parameter int MAX_BINS  = DEF_MAX_BINS,
   parameter int BIN_WIDTH = DEF_BIN_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sri_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sri_rsp_type        rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [RATIO_W-1:0] csr_wdata
);

   localparam int PosW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CntW  = $clog2(MAX_BINS + 1);
   localparam int SumW  = BIN_WIDTH + PosW;
   localparam int CopyW = (BIN_WIDTH < BIN_VALUE_W) ? BIN_WIDTH : BIN_VALUE_W;
   localparam int ExtW  = PosW + INDEX_W;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_THRESH,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [SumW-1:0]    total_ff, total_in;
   logic               ovf_ff, ovf_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sri_rsp_type        rsp_data_ff, rsp_data_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;

   logic                 req_xfer;
   logic                 room;
   logic [BIN_WIDTH-1:0] bin_masked;
   logic                 mem_wr;
   logic                 mem_rd;
   logic [PosW-1:0]      mem_rd_addr;
   logic [BIN_WIDTH-1:0] mem_rd_data;
   logic                 scan_reach;
   logic                 last_pos;
   logic                 hit;
   logic [ExtW-1:0]      pos_ext;
   sri_scan_ctrl_type    scan_ctrl;

   sri_bin_mem #(
      .DEPTH (MAX_BINS),
      .WIDTH (BIN_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (count_ff[PosW-1:0]),
      .wr_data (bin_masked),
      .rd_en   (mem_rd),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sri_scan #(
      .MAX_BINS  (MAX_BINS),
      .BIN_WIDTH (BIN_WIDTH)
   ) u_scan (
      .clock   (clock),
      .ctrl    (scan_ctrl),
      .total   (total_ff),
      .ratio   (ratio_ff),
      .rd_data (mem_rd_data),
      .reach   (scan_reach)
   );

   always_comb begin
      req_ready  = (state_ff == ST_LOAD);
      req_xfer   = req_valid && req_ready;
      room       = count_ff < CntW'(MAX_BINS);
      bin_masked = BIN_WIDTH'(req_data.bin_value[CopyW-1:0]);
      mem_wr     = req_xfer && room;

      last_pos   = (CntW'(pos_ff) + CntW'(1)) == count_ff;
      hit        = scan_reach || last_pos;
      mem_rd     = (state_ff == ST_THRESH) || ((state_ff == ST_SCAN) && !hit);
      mem_rd_addr = (state_ff == ST_THRESH) ? '0 : pos_ff + PosW'(1);

      scan_ctrl.start   = (state_ff == ST_THRESH);
      scan_ctrl.advance = (state_ff == ST_SCAN);

      pos_ext = ExtW'(pos_ff);

      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ratio_in     = (csr_valid && csr_ready) ? csr_wdata : ratio_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (room) begin
                  count_in = count_ff + CntW'(1);
                  total_in = total_ff + SumW'(bin_masked);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_bin) begin
                  state_in = ST_THRESH;
               end
            end
         end
         ST_THRESH: begin
            pos_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_DONE;
            end else begin
               pos_in = pos_ff + PosW'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.rolloff_index = pos_ext[INDEX_W-1:0];
               rsp_data_in.overflow_flag = ovf_ff;
               count_in                  = '0;
               total_in                  = '0;
               ovf_in                    = 1'b0;
               pos_in                    = '0;
               state_in                  = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ratio_ff     <= RATIO_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         ratio_ff     <= ratio_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   count_bound_a : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_BINS))
      else $error("bin count exceeds capacity");

   scan_in_frame_a : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CntW'(pos_ff) < count_ff))
      else $error("scan position beyond stored bins");

   mem_port_a : assert property (@(posedge clock) disable iff (reset)
      !(mem_wr && mem_rd))
      else $error("bin memory written and read in the same cycle");

   rsp_from_done_a : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside of done state");

   last_starts_scan_a : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.last_bin) |=> (state_ff == ST_THRESH))
      else $error("last bin transfer did not start the scan");

endmodule
